[design/spr_pkg.sv]
// Shared types and constants of the sine polarity and RMS observer.
// Used by every module of the block but spr_fifo; depends on nothing.
`default_nettype none

package spr_pkg;

	// Default window length and queue depth.
	localparam int WINDOW_LEN_DEF = 256;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port widths.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 2'd2;

	// Register reset values.
	localparam logic [9:0] STEP_ANGLE_RST = 10'd1;
	localparam logic [14:0] MIN_ANGLE_RST = 15'd90;
	localparam logic [14:0] MAX_ANGLE_RST = 15'd360;

	// Polarity codes in two's complement.
	localparam logic [1:0] POL_ZERO = 2'b00;
	localparam logic [1:0] POL_POS = 2'b01;
	localparam logic [1:0] POL_NEG = 2'b11;

	// A classified sample as it waits between front and back.
	typedef struct packed {
		logic neg;          // zero or negative sample
		logic [15:0] mag;   // magnitude, 0 to 32768
	} item_t;

	// One result word.
	typedef struct packed {
		logic [1:0] polarity;
		logic [15:0] phase_angle;
		logic [15:0] rms_value;
		logic rms_updated;
	} result_t;

endpackage

`default_nettype wire

[design/sine_polarity_and_rms_observer.sv]
// Top level of the sine polarity and windowed RMS observer.
// Uses spr_pkg, spr_front, spr_back and spr_fifo.
//
// Channel   Direction  Handshake               Payload
// input     in         push / full             sample
// result    out        empty / pop             polarity, phase_angle, rms_value, rms_updated
// config    in         cfg_we (no wait)        cfg_index, cfg_data
//
// For each sample the back first updates angle and polarity and registers the
// square, then adds it into the window sum.
// After the sample that closes a window, the root of the mean square is found
// one bit a cycle, with no divide by the window length.
// Reset is asynchronous and active low; no clearing pass follows.
// The back waits while the result queue is full; full rises only when the input
// queue is full.
`default_nettype none

module sine_polarity_and_rms_observer #(
	parameter int WINDOW_LEN = spr_pkg::WINDOW_LEN_DEF,
	parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic signed [15:0] sample,
	output logic empty,
	input  wire logic pop,
	output logic signed [1:0] polarity,
	output logic [15:0] phase_angle,
	output logic [15:0] rms_value,
	output logic rms_updated,
	input  wire logic cfg_we,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spr_pkg::CFG_DATA_W-1:0] cfg_data
);

	spr_pkg::item_t item;
	logic item_empty;
	logic item_pop;
	logic res_full;
	logic res_push;
	spr_pkg::result_t res_in;
	spr_pkg::result_t res_out;
	logic [$bits(spr_pkg::result_t)-1:0] res_rdata;

	// Front: classification of each sample and the queue that decouples
	// acceptance from the back.
	spr_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.item(item),
		.item_empty(item_empty),
		.item_pop(item_pop)
	);

	// Back: the observer state, the window sum and the root sequencer.
	// It only takes a sample when the result queue has room, so every word
	// it produces has a place to go.
	spr_back #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.item_empty(item_empty),
		.item_pop(item_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	// Result queue: the oldest result word sits on the output ports.
	spr_fifo #(
		.WIDTH($bits(spr_pkg::result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign res_out = spr_pkg::result_t'(res_rdata);
	assign polarity = res_out.polarity;
	assign phase_angle = res_out.phase_angle;
	assign rms_value = res_out.rms_value;
	assign rms_updated = res_out.rms_updated;

	// The back never offers a result word that the result queue cannot hold.
	a_no_res_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result word pushed into a full queue");

endmodule

`default_nettype wire

[design/spr_fifo.sv]
// Small register queue used between the front and the back and for results.
// Depends on nothing but its parameters.
`default_nettype none

module spr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic full,
	input  wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// The fill count never passes the depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

endmodule

`default_nettype wire

[design/spr_front.sv]
// Front part: accepts samples, sorts them into sign class and magnitude,
// and queues them for the back. Uses spr_pkg and spr_fifo.
`default_nettype none

module spr_front #(
	parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic signed [15:0] sample,
	output spr_pkg::item_t item,
	output logic item_empty,
	input  wire logic item_pop
);

	spr_pkg::item_t cls;
	logic [$bits(spr_pkg::item_t)-1:0] q_rdata;

	// A zero sample belongs to the negative class.
	always_comb begin
		cls.neg = sample[15] || (sample == 16'sd0);
		cls.mag = sample[15] ? (~$unsigned(sample) + 16'd1) : $unsigned(sample);
	end

	spr_fifo #(
		.WIDTH($bits(spr_pkg::item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(cls),
		.full(full),
		.pop(item_pop),
		.rdata(q_rdata),
		.empty(item_empty)
	);

	assign item = spr_pkg::item_t'(q_rdata);

endmodule

`default_nettype wire

[design/spr_back.sv]
// Back part: angle and polarity tracking, square accumulation, and the
// per-window root sequencer that takes the root of the mean square. Uses spr_pkg.
`default_nettype none

module spr_back #(
	parameter int WINDOW_LEN = spr_pkg::WINDOW_LEN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire spr_pkg::item_t item,
	input  wire logic item_empty,
	output logic item_pop,
	input  wire logic res_full,
	output logic res_push,
	output spr_pkg::result_t res
);

	localparam int CNT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W = 31 + CNT_W;
	localparam int RMW = CNT_W + 19;
	localparam int IW = 4;

	typedef enum logic [2:0] {
		ST_TAKE = 3'b001,
		ST_ACC  = 3'b010,
		ST_ROOT = 3'b100
	} state_t;

	state_t state_q;

	logic [9:0] step_q;
	logic [14:0] min_q;
	logic [14:0] max_q;

	logic [15:0] angle_q;
	logic last_neg_q;
	logic [1:0] pol_q;
	logic [15:0] rms_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [30:0] sq_s1;
	logic [RMW-1:0] rem_q;
	logic [RMW-1:0] nr_q;
	logic [IW-1:0] it_q;
	logic [15:0] root_q;

	logic [15:0] ang_sum;
	logic [31:0] prod;
	logic [SUM_W-1:0] sum_n;
	logic [RMW-1:0] rem_top;
	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic root_ge;
	logic [15:0] root_n;
	logic take;
	logic last_step;

	assign ang_sum = angle_q + 16'(step_q);
	assign prod = item.mag * item.mag;
	assign sum_n = sum_q + SUM_W'(sq_s1);

	// The root r of the mean is the largest r with WINDOW_LEN * r * r not above
	// the window sum, so the window length is folded into the trial values and
	// no divide is needed. nr_q holds WINDOW_LEN times the partial root, and the
	// top bits of the sum above bit 31 seed the remainder.
	assign rem_top = RMW'(sum_n >> 32);
	assign rem_sh = {rem_q[RMW-3:0], sum_q[31:30]};
	assign trial = {nr_q[RMW-3:0], 2'b00} + RMW'(WINDOW_LEN);
	assign root_ge = (rem_sh >= trial);
	assign root_n = {root_q[14:0], root_ge};
	assign take = (state_q == ST_TAKE) && !item_empty && !res_full;
	assign last_step = (it_q == '0);

	assign item_pop = take;

	always_comb begin
		res_push = 1'b0;
		res.polarity = pol_q;
		res.phase_angle = angle_q;
		res.rms_value = rms_q;
		res.rms_updated = 1'b0;
		case (state_q)
			ST_ACC: res_push = (cnt_q != CNT_W'(WINDOW_LEN - 1));
			ST_ROOT: begin
				if (last_step) begin
					res_push = 1'b1;
					res.rms_value = root_n;
					res.rms_updated = 1'b1;
				end
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1 <= prod[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			step_q <= spr_pkg::STEP_ANGLE_RST;
			min_q <= spr_pkg::MIN_ANGLE_RST;
			max_q <= spr_pkg::MAX_ANGLE_RST;
			angle_q <= '0;
			last_neg_q <= 1'b0;
			pol_q <= spr_pkg::POL_ZERO;
			rms_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			nr_q <= '0;
			it_q <= '0;
			root_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spr_pkg::REG_STEP_ANGLE: step_q <= cfg_data[9:0];
					spr_pkg::REG_MIN_ANGLE: min_q <= cfg_data;
					spr_pkg::REG_MAX_ANGLE: max_q <= cfg_data;
					default: step_q <= step_q;
				endcase
			end
			case (state_q)
				ST_TAKE: begin
					if (take) begin
						if (item.neg != last_neg_q) begin
							if (ang_sum < 16'(min_q)) begin
								pol_q <= spr_pkg::POL_ZERO;
							end else if (item.neg) begin
								pol_q <= spr_pkg::POL_NEG;
							end else begin
								pol_q <= spr_pkg::POL_POS;
							end
							angle_q <= '0;
							last_neg_q <= item.neg;
						end else if (ang_sum > 16'(max_q)) begin
							pol_q <= spr_pkg::POL_ZERO;
							angle_q <= 16'(max_q);
						end else begin
							angle_q <= ang_sum;
						end
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q <= sum_n;
					if (cnt_q == CNT_W'(WINDOW_LEN - 1)) begin
						cnt_q <= '0;
						rem_q <= rem_top;
						nr_q <= '0;
						root_q <= '0;
						it_q <= IW'(15);
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						state_q <= ST_TAKE;
					end
				end
				ST_ROOT: begin
					// One root bit per step, two sum bits off the top.
					rem_q <= root_ge ? (rem_sh - trial) : rem_sh;
					nr_q <= {nr_q[RMW-2:0], 1'b0} + (root_ge ? RMW'(WINDOW_LEN) : '0);
					root_q <= root_n;
					if (last_step) begin
						rms_q <= root_n;
						sum_q <= '0;
						state_q <= ST_TAKE;
					end else begin
						sum_q <= {sum_q[SUM_W-3:0], 2'b00};
						it_q <= it_q - IW'(1);
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end

	// The stored angle is limited by the angle limit register and never
	// reaches bit 15.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q[15] == 1'b0)
		else $error("stored angle out of range");

	// The root remainder always stays below the gap to the next larger root.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < ({nr_q[RMW-2:0], 1'b0} + RMW'(WINDOW_LEN)))
		else $error("root remainder out of range");

endmodule

`default_nettype wire
